/* hw/rtl/wfba_pkg.sv */
// shared widths and codes for the worst-fit block allocator
`timescale 1ns / 1ps
`default_nettype none

package wfba_pkg;

    localparam int INDEX_W = 5;
    localparam int COUNT_W = 6;

    localparam logic [COUNT_W-1:0] COUNT_RESET = 6'd32;

    localparam logic ACT_LOAD  = 1'b0;
    localparam logic ACT_ALLOC = 1'b1;

endpackage

`default_nettype wire

/* hw/rtl/wfba_ram.sv */
// generic single-port-write, single-port-read ram with registered read data
`timescale 1ns / 1ps
`default_nettype none

module wfba_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 32
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

/* hw/rtl/worst_fit_block_allocator.sv */
// worst-fit block allocator: table of free sizes, largest block picked per request
// a load leaves busy low; an allocate over the blocks in use keeps busy high while
// the size ram's read port scans one entry per cycle and then the decide state runs,
// and pulses done once the decision is registered
// an allocate with no block in use answers in the next cycle
// after reset the size table is cleared, one entry a cycle, with busy high
`timescale 1ns / 1ps
`default_nettype none

module worst_fit_block_allocator
    import wfba_pkg::*;
#(
    parameter int NUM_BLOCKS = 32,
    parameter int SIZE_WIDTH = 16
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_we,
    input  wire logic [COUNT_W-1:0]    cfg_wdata,
    input  wire logic                  start,
    output logic                       busy,
    input  wire logic                  action,
    input  wire logic [INDEX_W-1:0]    block_index,
    input  wire logic [SIZE_WIDTH-1:0] size,
    output logic                       done,
    output logic                       granted,
    output logic [INDEX_W-1:0]         block_number,
    output logic [SIZE_WIDTH-1:0]      block_size_before,
    output logic [SIZE_WIDTH-1:0]      leftover
);

    localparam int AW = $clog2(NUM_BLOCKS);
    localparam int CW = $clog2(NUM_BLOCKS + 1);

    localparam logic [1:0] S_CLEAR = 2'd0;
    localparam logic [1:0] S_IDLE  = 2'd1;
    localparam logic [1:0] S_SCAN  = 2'd2;
    localparam logic [1:0] S_DONE  = 2'd3;

    logic [1:0]            state_reg, state_next;
    logic [CW-1:0]         addr_reg, addr_next;
    logic [CW-1:0]         used_reg, used_next;
    logic                  pend_reg, pend_next;
    logic [AW-1:0]         pend_idx_reg, pend_idx_next;
    logic [SIZE_WIDTH-1:0] best_size_reg, best_size_next;
    logic [AW-1:0]         best_idx_reg, best_idx_next;
    logic [SIZE_WIDTH-1:0] req_reg, req_next;
    logic [COUNT_W-1:0]    block_count_reg;

    logic                  done_reg, done_next;
    logic                  granted_reg, granted_next;
    logic [INDEX_W-1:0]    number_reg, number_next;
    logic [SIZE_WIDTH-1:0] before_reg, before_next;
    logic [SIZE_WIDTH-1:0] left_reg, left_next;

    logic                  ram_we;
    logic [AW-1:0]         ram_waddr;
    logic [SIZE_WIDTH-1:0] ram_wdata;
    logic [SIZE_WIDTH-1:0] ram_rdata;

    logic [CW-1:0]         used_now;
    logic                  accept;
    logic [SIZE_WIDTH-1:0] diff;

    wfba_ram #(
        .WIDTH (SIZE_WIDTH),
        .DEPTH (NUM_BLOCKS)
    ) u_sizes (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (addr_reg[AW-1:0]),
        .rdata (ram_rdata)
    );

    // counts above the table depth act as the full table
    assign used_now = (32'(block_count_reg) > NUM_BLOCKS) ? CW'(NUM_BLOCKS)
                                                          : CW'(block_count_reg);
    assign busy   = (state_reg != S_IDLE);
    assign accept = start && !busy;
    assign diff   = best_size_reg - req_reg;

    always_comb
    begin
        state_next     = state_reg;
        addr_next      = addr_reg;
        used_next      = used_reg;
        pend_next      = pend_reg;
        pend_idx_next  = pend_idx_reg;
        best_size_next = best_size_reg;
        best_idx_next  = best_idx_reg;
        req_next       = req_reg;
        done_next      = 1'b0;
        granted_next   = granted_reg;
        number_next    = number_reg;
        before_next    = before_reg;
        left_next      = left_reg;
        ram_we         = 1'b0;
        ram_waddr      = addr_reg[AW-1:0];
        ram_wdata      = '0;

        case (state_reg)
            S_CLEAR:
            begin
                ram_we = 1'b1;
                if (addr_reg == CW'(NUM_BLOCKS - 1))
                begin
                    addr_next  = '0;
                    state_next = S_IDLE;
                end
                else
                begin
                    addr_next = addr_reg + 1'b1;
                end
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    if (action == ACT_LOAD)
                    begin
                        // loads beyond the table are dropped
                        if (32'(block_index) < NUM_BLOCKS)
                        begin
                            ram_we    = 1'b1;
                            ram_waddr = AW'(block_index);
                            ram_wdata = size;
                        end
                    end
                    else if (used_now == '0)
                    begin
                        done_next    = 1'b1;
                        granted_next = 1'b0;
                        number_next  = '0;
                        before_next  = '0;
                        left_next    = '0;
                    end
                    else
                    begin
                        used_next      = used_now;
                        req_next       = size;
                        best_size_next = '0;
                        best_idx_next  = '0;
                        addr_next      = '0;
                        pend_next      = 1'b0;
                        state_next     = S_SCAN;
                    end
                end
            end
            S_SCAN:
            begin
                pend_next = 1'b0;
                if (addr_reg < used_reg)
                begin
                    pend_next     = 1'b1;
                    pend_idx_next = addr_reg[AW-1:0];
                    addr_next     = addr_reg + 1'b1;
                end
                // strict compare keeps the lowest index on a tie
                if (pend_reg && (ram_rdata > best_size_reg))
                begin
                    best_size_next = ram_rdata;
                    best_idx_next  = pend_idx_reg;
                end
                if (pend_reg && (addr_reg == used_reg))
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                done_next  = 1'b1;
                state_next = S_IDLE;
                if (req_reg <= best_size_reg)
                begin
                    granted_next = 1'b1;
                    number_next  = INDEX_W'(best_idx_reg);
                    before_next  = best_size_reg;
                    left_next    = diff;
                    ram_we       = 1'b1;
                    ram_waddr    = best_idx_reg;
                    ram_wdata    = diff;
                end
                else
                begin
                    granted_next = 1'b0;
                    number_next  = '0;
                    before_next  = '0;
                    left_next    = '0;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_CLEAR;
            addr_reg        <= '0;
            pend_reg        <= 1'b0;
            done_reg        <= 1'b0;
            block_count_reg <= COUNT_RESET;
        end
        else
        begin
            state_reg <= state_next;
            addr_reg  <= addr_next;
            pend_reg  <= pend_next;
            done_reg  <= done_next;
            if (cfg_we)
            begin
                block_count_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        used_reg      <= used_next;
        pend_idx_reg  <= pend_idx_next;
        best_size_reg <= best_size_next;
        best_idx_reg  <= best_idx_next;
        req_reg       <= req_next;
        granted_reg   <= granted_next;
        number_reg    <= number_next;
        before_reg    <= before_next;
        left_reg      <= left_next;
    end

    assign done              = done_reg;
    assign granted           = granted_reg;
    assign block_number      = number_reg;
    assign block_size_before = before_reg;
    assign leftover          = left_reg;

    a_left_le_before: assert property (@(posedge clk) disable iff (!rst_n)
        (done && granted) |-> (leftover <= block_size_before))
        else $error("leftover exceeds size before");

    a_wait_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !granted) |-> (block_number == '0 && block_size_before == '0
                                && leftover == '0))
        else $error("waiting result carries nonzero fields");

    a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN) |-> (addr_reg <= used_reg && used_reg != '0))
        else $error("scan address past blocks in use");

    a_done_from_idle_or_decide: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> ($past(state_reg) == S_DONE || $past(state_reg) == S_IDLE))
        else $error("result strobe outside decide or empty request");

endmodule

`default_nettype wire

/* dv/worst_fit_block_allocator_test.sv */
// self-checking testbench for the worst-fit block allocator
`timescale 1ns / 1ps
`default_nettype none

module worst_fit_block_allocator_test;
    import wfba_pkg::*;

    localparam int N_BLOCKS = 32;
    localparam int SIZE_W = 16;
    localparam int CYCLE_LIMIT = 500000;
    localparam int SETTLE_CYCLES = 40;

    typedef struct packed {
        logic               act;
        logic [INDEX_W-1:0] idx;
        logic [SIZE_W-1:0]  amount;
    } alloc_item_t;

    typedef struct packed {
        logic               granted;
        logic [INDEX_W-1:0] number;
        logic [SIZE_W-1:0]  prior;
        logic [SIZE_W-1:0]  left;
    } grant_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               cfg_we = 1'b0;
    logic [COUNT_W-1:0] cfg_wdata = '0;
    logic               start = 1'b0;
    logic               busy;
    logic               action = ACT_LOAD;
    logic [INDEX_W-1:0] block_index = '0;
    logic [SIZE_W-1:0]  size = '0;
    logic               done;
    logic               granted;
    logic [INDEX_W-1:0] block_number;
    logic [SIZE_W-1:0]  block_size_before;
    logic [SIZE_W-1:0]  leftover;

    alloc_item_t        item_q[$];
    grant_t             grant_q[$];
    logic [SIZE_W-1:0]  free_size[N_BLOCKS];
    logic [COUNT_W-1:0] blk_count = COUNT_RESET;

    int          errors = 0;
    int          cycles = 0;
    int          issued_cnt = 0;
    int          accepted_cnt = 0;
    int          result_cnt = 0;
    int          burst_left = 0;
    int          gap_left = 0;
    alloc_item_t next_item;

    worst_fit_block_allocator #(
        .NUM_BLOCKS (N_BLOCKS),
        .SIZE_WIDTH (SIZE_W)
    ) u_top (
        .clk               (clk),
        .rst_n             (rst_n),
        .cfg_we            (cfg_we),
        .cfg_wdata         (cfg_wdata),
        .start             (start),
        .busy              (busy),
        .action            (action),
        .block_index       (block_index),
        .size              (size),
        .done              (done),
        .granted           (granted),
        .block_number      (block_number),
        .block_size_before (block_size_before),
        .leftover          (leftover)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    task automatic report_mismatch(input string msg);
        $display("mismatch at cycle %0d: %s", cycles, msg);
        errors++;
    endtask

    // applies loads to, and makes the worst-fit choice on, the local copy of the table
    function automatic void predict_grant(input alloc_item_t it);
        grant_t           g;
        int               used;
        int               best;
        logic [SIZE_W-1:0] top;
        if (it.act == ACT_LOAD)
        begin
            free_size[it.idx] = it.amount;
            return;
        end
        g = '0;
        used = (blk_count > N_BLOCKS) ? N_BLOCKS : int'(blk_count);
        if (used != 0)
        begin
            best = 0;
            top = free_size[0];
            for (int k = 1; k < used; k++)
            begin
                if (free_size[k] > top)
                begin
                    top = free_size[k];
                    best = k;
                end
            end
            if (it.amount <= top)
            begin
                g.granted = 1'b1;
                g.number = best[INDEX_W-1:0];
                g.prior = top;
                g.left = top - it.amount;
                free_size[best] = g.left;
            end
        end
        grant_q.push_back(g);
    endfunction

    // driver: bursts of items with random gaps, new values at the falling edge
    always @(negedge clk)
    begin
        if (rst_n && accepted_cnt == issued_cnt)
        begin
            if (gap_left > 0)
            begin
                gap_left <= gap_left - 1;
                start <= 1'b0;
            end
            else if (item_q.size() > 0)
            begin
                next_item = item_q.pop_front();
                issued_cnt++;
                start <= 1'b1;
                action <= next_item.act;
                block_index <= next_item.idx;
                size <= next_item.amount;
                if (burst_left <= 1)
                begin
                    burst_left <= ($urandom_range(0, 3) == 0) ? $urandom_range(30, 60)
                                                               : $urandom_range(1, 10);
                    gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 25);
                end
                else
                begin
                    burst_left <= burst_left - 1;
                end
            end
            else
            begin
                start <= 1'b0;
            end
        end
    end

    // monitor: start transfers feed the predictor, done strobes are checked
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (start && !busy)
            begin
                accepted_cnt++;
                predict_grant('{act: action, idx: block_index, amount: size});
            end
            if (done)
            begin
                result_cnt++;
                if (grant_q.size() == 0)
                begin
                    report_mismatch($sformatf("result %0d with nothing outstanding", result_cnt));
                end
                else
                begin
                    grant_t g;
                    g = grant_q.pop_front();
                    if (granted !== g.granted)
                        report_mismatch($sformatf("result %0d granted %b, want %b",
                                                  result_cnt, granted, g.granted));
                    if (block_number !== g.number)
                        report_mismatch($sformatf("result %0d block_number %0d, want %0d",
                                                  result_cnt, block_number, g.number));
                    if (block_size_before !== g.prior)
                        report_mismatch($sformatf("result %0d block_size_before %0d, want %0d",
                                                  result_cnt, block_size_before, g.prior));
                    if (leftover !== g.left)
                        report_mismatch($sformatf("result %0d leftover %0d, want %0d",
                                                  result_cnt, leftover, g.left));
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("timeout: %0d results still outstanding", grant_q.size());
            $display("*** FAILED ***");
            $finish;
        end
    end

    task automatic add_item(input logic act, input int idx, input int amount);
        item_q.push_back('{act: act, idx: idx[INDEX_W-1:0], amount: amount[SIZE_W-1:0]});
    endtask

    task automatic write_block_count(input int n);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_wdata <= n[COUNT_W-1:0];
        blk_count = n[COUNT_W-1:0];
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    // waits until every item has gone in and every result has come back
    task automatic wait_drained();
        while (item_q.size() != 0 || issued_cnt != accepted_cnt || grant_q.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // mostly large loads and modest requests so both grants and waits occur
    task automatic queue_random(input int n);
        int pick;
        int amount;
        for (int i = 0; i < n; i++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 35)
            begin
                amount = ($urandom_range(0, 1) == 0) ? $urandom_range(16'h8000, 16'hffff)
                                                     : $urandom_range(0, 16'hffff);
                add_item(ACT_LOAD, $urandom_range(0, 31), amount);
            end
            else
            begin
                pick = $urandom_range(0, 99);
                if (pick < 10)
                    amount = 0;
                else if (pick < 50)
                    amount = $urandom_range(0, 511);
                else if (pick < 75)
                    amount = $urandom_range(0, 4095);
                else if (pick < 90)
                    amount = $urandom_range(0, 16'hffff);
                else
                    amount = $urandom_range(16'hff00, 16'hffff);
                add_item(ACT_ALLOC, $urandom_range(0, 31), amount);
            end
        end
    endtask

    initial
    begin
        int phase_counts[10];
        phase_counts = '{32, 1, 2, 63, 0, 7, 33, 16, 31, 0};
        phase_counts[9] = $urandom_range(1, 32);

        for (int k = 0; k < N_BLOCKS; k++)
            free_size[k] = '0;
        repeat (12) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        // table clearing pass after reset
        while (busy)
            @(negedge clk);

        // empty table, reset count: zero request fits, anything else is not granted until loads give room
        add_item(ACT_ALLOC, 0, 0);
        add_item(ACT_ALLOC, 31, 1);
        add_item(ACT_ALLOC, 5, 16'hffff);
        add_item(ACT_LOAD, 31, 16'hffff);
        add_item(ACT_LOAD, 0, 16'hffff);
        add_item(ACT_ALLOC, 31, 16'hffff);
        add_item(ACT_ALLOC, 0, 0);
        add_item(ACT_ALLOC, 0, 1);
        add_item(ACT_LOAD, 10, 16'h5555);
        add_item(ACT_LOAD, 21, 16'haaaa);
        add_item(ACT_ALLOC, 21, 16'haaab);
        add_item(ACT_ALLOC, 10, 16'h5555);
        wait_drained();

        // no block in use: every request waits
        write_block_count(0);
        add_item(ACT_ALLOC, 0, 0);
        add_item(ACT_LOAD, 0, 16'h1234);
        add_item(ACT_ALLOC, 0, 1);
        wait_drained();

        write_block_count(1);
        add_item(ACT_ALLOC, 31, 16'h1000);
        add_item(ACT_ALLOC, 0, 16'h0300);
        wait_drained();

        // load above the count only takes part once the count covers it
        write_block_count(4);
        add_item(ACT_LOAD, 20, 60000);
        add_item(ACT_ALLOC, 20, 100);
        wait_drained();
        write_block_count(63);
        add_item(ACT_ALLOC, 3, 100);
        add_item(ACT_ALLOC, 3, 65535);
        wait_drained();
        write_block_count(33);
        add_item(ACT_ALLOC, 0, 7);
        wait_drained();

        foreach (phase_counts[p])
        begin
            write_block_count(phase_counts[p]);
            queue_random(70);
            wait_drained();
        end

        if (errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

`default_nettype wire
